### hw/rtl/via_pkg.sv
// Shared types and constants of the versatile interface adapter.
package via_pkg;

  typedef enum logic [2:0] {
    CMD_BUS_READ  = 3'd0,
    CMD_BUS_WRITE = 3'd1,
    CMD_TICK      = 3'd2,
    CMD_CA1_LEVEL = 3'd3,
    CMD_EXT_A     = 3'd4,
    CMD_EXT_B     = 3'd5
  } via_cmd_e;

  typedef enum logic [3:0] {
    REG_ORB   = 4'd0,
    REG_ORA   = 4'd1,
    REG_DDRB  = 4'd2,
    REG_DDRA  = 4'd3,
    REG_T1CL  = 4'd4,
    REG_T1CH  = 4'd5,
    REG_T1LL  = 4'd6,
    REG_T1LH  = 4'd7,
    REG_T2CL  = 4'd8,
    REG_T2CH  = 4'd9,
    REG_SR    = 4'd10,
    REG_ACR   = 4'd11,
    REG_PCR   = 4'd12,
    REG_IFR   = 4'd13,
    REG_IER   = 4'd14,
    REG_ORA_NH = 4'd15
  } via_reg_e;

  // Control line modes (PCR fields)
  localparam logic [2:0] MODE_PULSE = 3'b101;
  localparam logic [2:0] MODE_LOW   = 3'b110;
  localparam logic [2:0] MODE_HIGH  = 3'b111;

  localparam int FlagWidth = 7;
  localparam logic [FlagWidth-1:0] FLAG_CA2 = 7'h01;
  localparam logic [FlagWidth-1:0] FLAG_CA1 = 7'h02;
  localparam logic [FlagWidth-1:0] FLAG_SR  = 7'h04;
  localparam logic [FlagWidth-1:0] FLAG_CB1 = 7'h10;
  localparam logic [FlagWidth-1:0] FLAG_T2  = 7'h20;
  localparam logic [FlagWidth-1:0] FLAG_T1  = 7'h40;

  localparam int AcrFreeRunBit = 6;
  localparam logic [1:0] CA2_PULSE_TICKS = 2'd2;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] port_mask;
    logic       ca1_level;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_event;
    logic       ca2_drive;
    logic       ca2_level;
    logic       cb2_drive;
    logic       cb2_level;
    logic       portb_written;
    logic [7:0] portb_value;
    logic [7:0] shift_value;
  } result_t;

endpackage

### hw/rtl/via_in_stage.sv
// Input register: captures one item per transfer and holds it until the core takes it.
module via_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  via_pkg::item_t item_i,
  input  logic          advance_i,
  output logic          valid_o,
  output via_pkg::item_t item_o
);
  import via_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### hw/rtl/via_core.sv
// Register file, timer 1, control lines and interrupt flags; one item per enabled cycle.
module via_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  via_pkg::item_t   item_i,
  output via_pkg::result_t result_o
);
  import via_pkg::*;

  logic [7:0]           port_a_q, port_a_d;
  logic [7:0]           port_b_q, port_b_d;
  logic [7:0]           dir_a_q, dir_a_d;
  logic [7:0]           dir_b_q, dir_b_d;
  logic [15:0]          t1_count_q, t1_count_d;
  logic [15:0]          t1_latch_q, t1_latch_d;
  logic [15:0]          t2_count_q, t2_count_d;
  logic [7:0]           t2_latch_lo_q, t2_latch_lo_d;
  logic [7:0]           shift_q, shift_d;
  logic [7:0]           acr_q, acr_d;
  logic [7:0]           pcr_q, pcr_d;
  logic [FlagWidth-1:0] flags_q, flags_d;
  logic [7:0]           ier_q, ier_d;
  logic                 ca1_last_q, ca1_last_d;
  logic [1:0]           pulse_q, pulse_d;
  logic                 handshake;
  result_t              res;

  always_comb begin
    port_a_d      = port_a_q;
    port_b_d      = port_b_q;
    dir_a_d       = dir_a_q;
    dir_b_d       = dir_b_q;
    t1_count_d    = t1_count_q;
    t1_latch_d    = t1_latch_q;
    t2_count_d    = t2_count_q;
    t2_latch_lo_d = t2_latch_lo_q;
    shift_d       = shift_q;
    acr_d         = acr_q;
    pcr_d         = pcr_q;
    flags_d       = flags_q;
    ier_d         = ier_q;
    ca1_last_d    = ca1_last_q;
    pulse_d       = pulse_q;
    handshake     = 1'b0;
    res           = '0;

    if (en_i) begin
      unique case (via_cmd_e'(item_i.command))
        CMD_BUS_READ: begin
          unique case (via_reg_e'(item_i.reg_addr))
            REG_ORB: begin
              flags_d       = flags_q & ~FLAG_CB1;
              res.read_data = port_b_q;
            end
            REG_ORA: begin
              handshake     = 1'b1;
              res.read_data = port_a_q;
            end
            REG_DDRB:   res.read_data = dir_b_q;
            REG_DDRA:   res.read_data = dir_a_q;
            REG_T1CL:   res.read_data = t1_count_q[7:0];
            REG_T1CH:   res.read_data = t1_count_q[15:8];
            REG_T1LL:   res.read_data = t1_latch_q[7:0];
            REG_T1LH:   res.read_data = t1_latch_q[15:8];
            REG_T2CL:   res.read_data = t2_count_q[7:0];
            REG_T2CH:   res.read_data = t2_count_q[15:8];
            REG_SR:     res.read_data = shift_q;
            REG_ACR:    res.read_data = acr_q;
            REG_PCR:    res.read_data = pcr_q;
            REG_IFR:    res.read_data = (flags_q != '0) ? {1'b1, flags_q} : 8'd0;
            REG_IER:    res.read_data = ier_q;
            REG_ORA_NH: res.read_data = port_a_q;
            default:    res.read_data = port_a_q;
          endcase
        end
        CMD_BUS_WRITE: begin
          unique case (via_reg_e'(item_i.reg_addr))
            REG_ORB: begin
              port_b_d          = item_i.write_data;
              flags_d           = flags_q & ~FLAG_CB1;
              res.portb_written = 1'b1;
              res.portb_value   = item_i.write_data;
            end
            REG_ORA: begin
              port_a_d  = item_i.write_data;
              handshake = 1'b1;
            end
            REG_DDRB: dir_b_d = item_i.write_data;
            REG_DDRA: dir_a_d = item_i.write_data;
            REG_T1CL, REG_T1LL: t1_latch_d = {t1_latch_q[15:8], item_i.write_data};
            REG_T1CH: t1_count_d = {item_i.write_data, t1_count_q[7:0]};
            REG_T1LH: t1_latch_d = {item_i.write_data, t1_latch_q[7:0]};
            REG_T2CL: t2_latch_lo_d = item_i.write_data;
            REG_T2CH: begin
              t2_count_d = {item_i.write_data, t2_latch_lo_q};
              flags_d    = flags_q & ~FLAG_T2;
            end
            REG_SR: begin
              shift_d = item_i.write_data;
              flags_d = flags_q | FLAG_SR;
            end
            REG_ACR: acr_d = item_i.write_data;
            REG_PCR: begin
              pcr_d = item_i.write_data;
              if (item_i.write_data[7:5] == MODE_HIGH) begin
                res.cb2_drive = 1'b1;
                res.cb2_level = 1'b1;
              end else if (item_i.write_data[7:5] == MODE_LOW) begin
                res.cb2_drive = 1'b1;
              end
              if (item_i.write_data[3:1] == MODE_HIGH) begin
                res.ca2_drive = 1'b1;
                res.ca2_level = 1'b1;
              end else if (item_i.write_data[3:1] == MODE_LOW) begin
                res.ca2_drive = 1'b1;
              end
            end
            REG_IFR: flags_d = flags_q & ~item_i.write_data[FlagWidth-1:0];
            REG_IER: ier_d = item_i.write_data;
            default: port_a_d = item_i.write_data;
          endcase
        end
        CMD_TICK: begin
          if (acr_q[AcrFreeRunBit]) begin
            if (t1_count_q != 16'd0) begin
              t1_count_d = t1_count_q - 16'd1;
            end else begin
              flags_d       = flags_q | FLAG_T1;
              res.irq_event = |(FLAG_T1 & ier_q[FlagWidth-1:0]);
              t1_count_d    = t1_latch_q;
            end
          end else if (t1_count_q != 16'd0) begin
            t1_count_d = t1_count_q - 16'd1;
            if (t1_count_q == 16'd1) begin
              flags_d       = flags_q | FLAG_T1;
              res.irq_event = |(FLAG_T1 & ier_q[FlagWidth-1:0]);
            end
          end
          // release CA2 when the pulse runs out
          if (pulse_q != 2'd0) begin
            pulse_d = pulse_q - 2'd1;
            if (pulse_q == 2'd1) begin
              res.ca2_drive = 1'b1;
              res.ca2_level = 1'b1;
            end
          end
        end
        CMD_CA1_LEVEL: begin
          if ((pcr_q[0] && !ca1_last_q && item_i.ca1_level) ||
              (!pcr_q[0] && ca1_last_q && !item_i.ca1_level)) begin
            flags_d       = flags_q | FLAG_CA1;
            res.irq_event = |(FLAG_CA1 & ier_q[FlagWidth-1:0]);
          end
          ca1_last_d = item_i.ca1_level;
        end
        CMD_EXT_A: port_a_d = (port_a_q & ~item_i.port_mask) |
                              (item_i.write_data & item_i.port_mask);
        CMD_EXT_B: port_b_d = (port_b_q & ~item_i.port_mask) |
                              (item_i.write_data & item_i.port_mask);
        default: ;
      endcase

      // port A handshake: clear CA1/CA2 flags, start the CA2 pulse in pulse mode
      if (handshake) begin
        flags_d = flags_q & ~(FLAG_CA1 | FLAG_CA2);
        if (pcr_q[3:1] == MODE_PULSE) begin
          pulse_d       = CA2_PULSE_TICKS;
          res.ca2_drive = 1'b1;
          res.ca2_level = 1'b0;
        end
      end
    end

    res.shift_value = shift_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_a_q      <= '0;
      port_b_q      <= '0;
      dir_a_q       <= '0;
      dir_b_q       <= '0;
      t1_count_q    <= '0;
      t1_latch_q    <= '0;
      t2_count_q    <= '0;
      t2_latch_lo_q <= '0;
      shift_q       <= '0;
      acr_q         <= '0;
      pcr_q         <= '0;
      flags_q       <= '0;
      ier_q         <= '0;
      ca1_last_q    <= 1'b1;
      pulse_q       <= '0;
    end else begin
      port_a_q      <= port_a_d;
      port_b_q      <= port_b_d;
      dir_a_q       <= dir_a_d;
      dir_b_q       <= dir_b_d;
      t1_count_q    <= t1_count_d;
      t1_latch_q    <= t1_latch_d;
      t2_count_q    <= t2_count_d;
      t2_latch_lo_q <= t2_latch_lo_d;
      shift_q       <= shift_d;
      acr_q         <= acr_d;
      pcr_q         <= pcr_d;
      flags_q       <= flags_d;
      ier_q         <= ier_d;
      ca1_last_q    <= ca1_last_d;
      pulse_q       <= pulse_d;
    end
  end

  assign result_o = res;

  a_ifr_read_keeps_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && item_i.command == CMD_BUS_READ && item_i.reg_addr == REG_IFR
    |=> flags_q == $past(flags_q))
    else $error("IFR read changed the interrupt flags");

  a_irq_has_enabled_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && res.irq_event |=> (flags_q & ier_q[FlagWidth-1:0]) != '0)
    else $error("irq_event without an enabled flag set");

  a_pulse_end_drives_high : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && item_i.command == CMD_TICK && pulse_q == 2'd1
    |-> res.ca2_drive && res.ca2_level && pulse_d == 2'd0)
    else $error("CA2 pulse end did not drive CA2 high");

  a_pulse_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_q != 2'd3)
    else $error("CA2 pulse count out of range");

endmodule

### hw/rtl/via_out_stage.sv
// Result register: holds one result until the downstream transfer.
module via_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  via_pkg::result_t result_i,
  output logic             take_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output via_pkg::result_t result_o
);
  import via_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // accept a new result when empty or when the held one leaves now
  assign take_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (take_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && take_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

### hw/rtl/versatile_interface_adapter_unit.sv
// Top level of the versatile interface adapter (simplified 6522).
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------------
//   in      | input     | in_valid_i / in_ready_o   | command, reg_addr, write_data,
//           |           |                           | port_mask, ca1_level
//   out     | output    | out_valid_o / out_ready_i | read_data, irq_event, ca2/cb2
//           |           |                           | drive and level, portb, shift
//
// One item per cycle while the output is not stalled: an item is held in the input
// register, then the core updates its state and loads the result register, and the
// result is on the output from there. Rate is set by the single core step per item.
// Reset is asynchronous and clears the core state and the valid bits (CA1 last level
// to one); the item and result data registers are not reset. A stalled output holds
// the result register; the input register keeps taking items while either stage has room.
module versatile_interface_adapter_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] command_i,
  input  logic [3:0] reg_addr_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] port_mask_i,
  input  logic       ca1_level_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       irq_event_o,
  output logic       ca2_drive_o,
  output logic       ca2_level_o,
  output logic       cb2_drive_o,
  output logic       cb2_level_o,
  output logic       portb_written_o,
  output logic [7:0] portb_value_o,
  output logic [7:0] shift_value_o
);
  import via_pkg::*;

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    take;
  logic    advance;
  result_t core_result;
  result_t out_result;

  assign in_item.command    = command_i;
  assign in_item.reg_addr   = reg_addr_i;
  assign in_item.write_data = write_data_i;
  assign in_item.port_mask  = port_mask_i;
  assign in_item.ca1_level  = ca1_level_i;

  assign advance = stage_valid && take;

  via_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  via_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (stage_item),
    .result_o (core_result)
  );

  via_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (stage_valid),
    .result_i    (core_result),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign read_data_o     = out_result.read_data;
  assign irq_event_o     = out_result.irq_event;
  assign ca2_drive_o     = out_result.ca2_drive;
  assign ca2_level_o     = out_result.ca2_level;
  assign cb2_drive_o     = out_result.cb2_drive;
  assign cb2_level_o     = out_result.cb2_level;
  assign portb_written_o = out_result.portb_written;
  assign portb_value_o   = out_result.portb_value;
  assign shift_value_o   = out_result.shift_value;

endmodule
